### rtl/assert_macros.svh
// assertion helpers, empty under synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SVM_CHECK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SVM_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define SVM_CHECK(label, prop, msg)
`define SVM_IMPLY(label, ante, cons, msg)
`endif
`endif

### rtl/svm_pkg.sv
`default_nettype none
package svm_pkg;
    localparam int unsigned TIME_BITS = 31;
    localparam int unsigned NUM_BITS = 62;
    localparam int unsigned DIV_STEPS = 31;
    localparam logic [28:0] SQRT3_Q28 = 29'd464943848;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
    localparam logic [30:0] PERIOD_RESET = 31'd65536;

    localparam logic [2:0] SECTOR_1 = 3'd1;
    localparam logic [2:0] SECTOR_2 = 3'd2;
    localparam logic [2:0] SECTOR_3 = 3'd3;
    localparam logic [2:0] SECTOR_4 = 3'd4;
    localparam logic [2:0] SECTOR_5 = 3'd5;
    localparam logic [2:0] SECTOR_6 = 3'd6;

    typedef struct packed {
        logic [2:0]  sector;
        logic [30:0] bus;
    } svm_side_t;

    typedef struct packed {
        svm_side_t             side;
        logic [NUM_BITS-1:0]   num1;
        logic [NUM_BITS-1:0]   num2;
    } svm_front_t;

    typedef struct packed {
        logic                  sat;
        logic [TIME_BITS-1:0]  rem;
        logic [TIME_BITS-1:0]  dvd;
        logic [TIME_BITS-1:0]  quo;
    } svm_lane_t;

    typedef struct packed {
        svm_side_t side;
        svm_lane_t ln1;
        svm_lane_t ln2;
    } svm_div_t;
endpackage
`default_nettype wire

### rtl/space_vector_modulation_top.sv
// path: each input beat passes the front, multiply, divide and map stages in that order
// throughput: one beat per cycle while the output is not stalled; two 31-step restoring dividers run as pipelines
// each pipeline stage holds only while its successor is full and stalled
// reset: all stages empty, the switching period register returns to 65536
`default_nettype none
`include "assert_macros.svh"
module space_vector_modulation_top import svm_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic [30:0]        cfg_wr_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [31:0] alpha_voltage,
    input  wire logic signed [31:0] beta_voltage,
    input  wire logic [30:0]        bus_voltage,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [2:0]              sector,
    output logic signed [31:0]      time_u,
    output logic signed [31:0]      time_v,
    output logic signed [31:0]      time_w,
    output logic                    overmodulated,
    output logic                    bus_zero
);
    logic [30:0] period_reg;
    logic        front_ready, front_valid, mul_ready, mul_valid;
    logic        div_ready, div_valid, map_ready;
    svm_front_t  front_data;
    svm_div_t    mul_data, div_data;
    logic [31:0] tu_w, tv_w, tw_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            period_reg <= PERIOD_RESET;
        else if (cfg_wr_en)
            period_reg <= cfg_wr_data;
    end

    assign in_stall = !front_ready;
    assign time_u   = $signed(tu_w);
    assign time_v   = $signed(tv_w);
    assign time_w   = $signed(tw_w);

    svm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (in_valid),
        .up_ready (front_ready),
        .alpha    (alpha_voltage),
        .beta     (beta_voltage),
        .bus      (bus_voltage),
        .dn_valid (front_valid),
        .dn_ready (mul_ready),
        .dn_data  (front_data)
    );

    svm_mul u_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .period   (period_reg),
        .up_valid (front_valid),
        .up_ready (mul_ready),
        .up_data  (front_data),
        .dn_valid (mul_valid),
        .dn_ready (div_ready),
        .dn_data  (mul_data)
    );

    svm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (mul_valid),
        .up_ready (div_ready),
        .up_data  (mul_data),
        .dn_valid (div_valid),
        .dn_ready (map_ready),
        .dn_data  (div_data)
    );

    svm_map u_map (
        .clk           (clk),
        .rst_n         (rst_n),
        .period        (period_reg),
        .up_valid      (div_valid),
        .up_ready      (map_ready),
        .up_data       (div_data),
        .dn_valid      (out_valid),
        .dn_ready      (!out_stall),
        .sector        (sector),
        .time_u        (tu_w),
        .time_v        (tv_w),
        .time_w        (tw_w),
        .overmodulated (overmodulated),
        .bus_zero      (bus_zero)
    );

    `SVM_IMPLY(a_sector_range, out_valid, (sector >= SECTOR_1 && sector <= SECTOR_6), "sector out of range")
    `SVM_IMPLY(a_bus_zero_times, out_valid && bus_zero, (tu_w == 32'd0 && tv_w == 32'd0 && tw_w == 32'd0 && !overmodulated), "bus zero with nonzero times")
    `SVM_IMPLY(a_over_phase_off, out_valid && overmodulated, (tu_w == 32'd0 || tv_w == 32'd0 || tw_w == 32'd0), "overmodulation without an off phase")
    `SVM_CHECK(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(sector) && $stable(tu_w) && $stable(tv_w) && $stable(tw_w) && $stable(overmodulated) && $stable(bus_zero)), "result beat changed while stalled")
endmodule
`default_nettype wire

### rtl/svm_front.sv
`default_nettype none
module svm_front import svm_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               up_valid,
    output logic                    up_ready,
    input  wire logic signed [31:0] alpha,
    input  wire logic signed [31:0] beta,
    input  wire logic [30:0]        bus,
    output logic                    dn_valid,
    input  wire logic               dn_ready,
    output svm_front_t              dn_data
);
    logic               v1_reg, v2_reg, rdy1, rdy2;
    logic signed [31:0] alpha1_reg, beta1_reg;
    logic [30:0]        bus1_reg;
    logic signed [61:0] sa1_reg, sb1_reg;
    logic signed [61:0] sa_next, sb_next;
    svm_front_t         out_reg, out_next;

    logic signed [63:0] sa_w, sb_w, b28_w, a28x3_w, x2_w, y2_w, z2_w, n1_w, n2_w;
    logic signed [33:0] a3_w;

    assign rdy2     = !v2_reg || dn_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign up_ready = rdy1;
    assign dn_valid = v2_reg;
    assign dn_data  = out_reg;

    assign sa_next = alpha * $signed({1'b0, SQRT3_Q28});
    assign sb_next = beta * $signed({1'b0, SQRT3_Q28});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= up_valid;
            if (rdy2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            alpha1_reg <= alpha;
            beta1_reg  <= beta;
            bus1_reg   <= bus;
            sa1_reg    <= sa_next;
            sb1_reg    <= sb_next;
        end
        if (rdy2)
            out_reg <= out_next;
    end

    always_comb
    begin
        sa_w    = {{2{sa1_reg[61]}}, sa1_reg};
        sb_w    = {{2{sb1_reg[61]}}, sb1_reg};
        b28_w   = {{4{beta1_reg[31]}}, beta1_reg, 28'd0};
        a3_w    = {{2{alpha1_reg[31]}}, alpha1_reg} + {alpha1_reg[31], alpha1_reg, 1'b0};
        a28x3_w = {{2{a3_w[33]}}, a3_w, 28'd0};
        x2_w    = sb_w <<< 1;
        y2_w    = sb_w + a28x3_w;
        z2_w    = sb_w - a28x3_w;

        out_next.side.bus = bus1_reg;
        if (alpha1_reg == 32'sd0 && beta1_reg == 32'sd0)
            out_next.side.sector = SECTOR_1;
        else if (!beta1_reg[31])
            out_next.side.sector = (b28_w < sa_w) ? SECTOR_1 :
                                   (b28_w > -sa_w) ? SECTOR_2 : SECTOR_3;
        else
            out_next.side.sector = (b28_w > sa_w) ? SECTOR_4 :
                                   (b28_w < -sa_w) ? SECTOR_5 : SECTOR_6;

        case (out_next.side.sector)
            SECTOR_1:
            begin
                n1_w = -z2_w;
                n2_w = x2_w;
            end
            SECTOR_2:
            begin
                n1_w = y2_w;
                n2_w = z2_w;
            end
            SECTOR_3:
            begin
                n1_w = x2_w;
                n2_w = -y2_w;
            end
            SECTOR_4:
            begin
                n1_w = z2_w;
                n2_w = -x2_w;
            end
            SECTOR_5:
            begin
                n1_w = -y2_w;
                n2_w = -z2_w;
            end
            default:
            begin
                n1_w = -x2_w;
                n2_w = y2_w;
            end
        endcase

        // negative dwell clamps to zero
        out_next.num1 = (n1_w <= 64'sd0) ? '0 : n1_w[NUM_BITS-1:0];
        out_next.num2 = (n2_w <= 64'sd0) ? '0 : n2_w[NUM_BITS-1:0];
    end
endmodule
`default_nettype wire

### rtl/svm_mul.sv
`default_nettype none
module svm_mul import svm_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [30:0] period,
    input  wire logic        up_valid,
    output logic             up_ready,
    input  wire svm_front_t  up_data,
    output logic             dn_valid,
    input  wire logic        dn_ready,
    output svm_div_t         dn_data
);
    logic        v1_reg, v2_reg, rdy1, rdy2;
    svm_side_t   side1_reg;
    logic [61:0] lo1_reg, hi1_reg, lo2_reg, hi2_reg;
    svm_div_t    out_reg, out_next;

    logic [92:0] p1_w, p2_w;
    logic [63:0] d1_w, d2_w;

    assign rdy2     = !v2_reg || dn_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign up_ready = rdy1;
    assign dn_valid = v2_reg;
    assign dn_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= up_valid;
            if (rdy2)
                v2_reg <= v1_reg;
        end
    end

    // partial products over the two halves of the numerator
    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            side1_reg <= up_data.side;
            lo1_reg   <= up_data.num1[30:0] * period;
            hi1_reg   <= up_data.num1[61:31] * period;
            lo2_reg   <= up_data.num2[30:0] * period;
            hi2_reg   <= up_data.num2[61:31] * period;
        end
        if (rdy2)
            out_reg <= out_next;
    end

    always_comb
    begin
        p1_w = {hi1_reg, 31'd0} + {31'd0, lo1_reg};
        p2_w = {hi2_reg, 31'd0} + {31'd0, lo2_reg};
        d1_w = p1_w[92:29];
        d2_w = p2_w[92:29];

        out_next.side    = side1_reg;
        out_next.ln1.sat = d1_w[63:31] >= {2'd0, side1_reg.bus};
        out_next.ln1.rem = d1_w[61:31];
        out_next.ln1.dvd = d1_w[30:0];
        out_next.ln1.quo = '0;
        out_next.ln2.sat = d2_w[63:31] >= {2'd0, side1_reg.bus};
        out_next.ln2.rem = d2_w[61:31];
        out_next.ln2.dvd = d2_w[30:0];
        out_next.ln2.quo = '0;
    end
endmodule
`default_nettype wire

### rtl/svm_div.sv
`default_nettype none
module svm_div import svm_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     up_valid,
    output logic          up_ready,
    input  wire svm_div_t up_data,
    output logic          dn_valid,
    input  wire logic     dn_ready,
    output svm_div_t      dn_data
);
    logic                 v_reg   [DIV_STEPS];
    svm_div_t             stg_reg [DIV_STEPS];
    logic [DIV_STEPS:0]   rdy;

    function automatic svm_lane_t div_step(input svm_lane_t ln, input logic [30:0] bus);
        logic [31:0] r;
        logic        ge;
        svm_lane_t   o;
        r     = {ln.rem, ln.dvd[30]};
        ge    = r >= {1'b0, bus};
        o.sat = ln.sat;
        o.rem = ge ? 31'(r - {1'b0, bus}) : r[30:0];
        o.dvd = {ln.dvd[29:0], 1'b0};
        o.quo = {ln.quo[29:0], ge};
        return o;
    endfunction

    assign rdy[DIV_STEPS] = dn_ready;
    assign up_ready       = rdy[0];
    assign dn_valid       = v_reg[DIV_STEPS-1];
    assign dn_data        = stg_reg[DIV_STEPS-1];

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        logic     vin;
        svm_div_t din, stg_next;

        if (k == 0)
        begin : g_first
            assign vin = up_valid;
            assign din = up_data;
        end
        else
        begin : g_rest
            assign vin = v_reg[k-1];
            assign din = stg_reg[k-1];
        end

        assign rdy[k] = !v_reg[k] || rdy[k+1];

        always_comb
        begin
            stg_next.side = din.side;
            stg_next.ln1  = div_step(din.ln1, din.side.bus);
            stg_next.ln2  = div_step(din.ln2, din.side.bus);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (rdy[k])
                v_reg[k] <= vin;
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k])
                stg_reg[k] <= stg_next;
        end
    end
endmodule
`default_nettype wire

### rtl/svm_map.sv
`default_nettype none
module svm_map import svm_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [30:0] period,
    input  wire logic        up_valid,
    output logic             up_ready,
    input  wire svm_div_t    up_data,
    output logic             dn_valid,
    input  wire logic        dn_ready,
    output logic [2:0]       sector,
    output logic [31:0]      time_u,
    output logic [31:0]      time_v,
    output logic [31:0]      time_w,
    output logic             overmodulated,
    output logic             bus_zero
);
    logic        v_reg, rdy;
    logic [2:0]  sector_reg;
    logic [30:0] tu_reg, tv_reg, tw_reg, tu_next, tv_next, tw_next;
    logic        over_reg, over_next, bz_reg, bz_next;
    logic [30:0] t1_w, t2_w, sum_w, half_w, full_w, mid1_w, mid2_w, left_w;

    function automatic logic [30:0] sat_add(input logic [30:0] a, input logic [30:0] b);
        logic [31:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[31] ? TIME_MAX : s[30:0];
    endfunction

    assign rdy           = !v_reg || dn_ready;
    assign up_ready      = rdy;
    assign dn_valid      = v_reg;
    assign sector        = sector_reg;
    assign time_u        = {1'b0, tu_reg};
    assign time_v        = {1'b0, tv_reg};
    assign time_w        = {1'b0, tw_reg};
    assign overmodulated = over_reg;
    assign bus_zero      = bz_reg;

    always_comb
    begin
        t1_w   = up_data.ln1.sat ? TIME_MAX : up_data.ln1.quo;
        t2_w   = up_data.ln2.sat ? TIME_MAX : up_data.ln2.quo;
        sum_w  = sat_add(t1_w, t2_w);
        left_w = period - sum_w;
        bz_next = up_data.side.bus == 31'd0;
        over_next = !bz_next && (sum_w > period);
        half_w = (sum_w > period) ? '0 : {1'b0, left_w[30:1]};
        full_w = sat_add(sum_w, half_w);
        mid1_w = sat_add(t1_w, half_w);
        mid2_w = sat_add(t2_w, half_w);

        case (up_data.side.sector)
            SECTOR_1:
            begin
                tu_next = full_w;
                tv_next = mid2_w;
                tw_next = half_w;
            end
            SECTOR_2:
            begin
                tv_next = full_w;
                tu_next = mid1_w;
                tw_next = half_w;
            end
            SECTOR_3:
            begin
                tv_next = full_w;
                tw_next = mid2_w;
                tu_next = half_w;
            end
            SECTOR_4:
            begin
                tw_next = full_w;
                tv_next = mid1_w;
                tu_next = half_w;
            end
            SECTOR_5:
            begin
                tw_next = full_w;
                tu_next = mid2_w;
                tv_next = half_w;
            end
            default:
            begin
                tu_next = full_w;
                tw_next = mid1_w;
                tv_next = half_w;
            end
        endcase

        if (bz_next)
        begin
            tu_next = '0;
            tv_next = '0;
            tw_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (rdy)
            v_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (rdy)
        begin
            sector_reg <= up_data.side.sector;
            tu_reg     <= tu_next;
            tv_reg     <= tv_next;
            tw_reg     <= tw_next;
            over_reg   <= over_next;
            bz_reg     <= bz_next;
        end
    end
endmodule
`default_nettype wire

### tb/svm_checker.sv
`default_nettype none
module svm_checker import svm_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic [30:0]        cfg_wr_data,
    input  wire logic               in_valid,
    input  wire logic               in_stall,
    input  wire logic signed [31:0] alpha_voltage,
    input  wire logic signed [31:0] beta_voltage,
    input  wire logic [30:0]        bus_voltage,
    input  wire logic               out_valid,
    input  wire logic               out_stall,
    input  wire logic [2:0]         sector,
    input  wire logic signed [31:0] time_u,
    input  wire logic signed [31:0] time_v,
    input  wire logic signed [31:0] time_w,
    input  wire logic               overmodulated,
    input  wire logic               bus_zero,
    output int                      fail_count,
    output int                      pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]  sec;
        logic [31:0] tu;
        logic [31:0] tv;
        logic [31:0] tw;
        logic        over;
        logic        bz;
    } phase_times_t;

    phase_times_t expected_times[$];
    logic [30:0]  period;

    function automatic logic [30:0] sat_add(logic [30:0] a, logic [30:0] b);
        logic [31:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[31] ? TIME_MAX : s[30:0];
    endfunction

    // dwell = period * num / (bus * 2^29), clamped
    function automatic logic [30:0] dwell_time(longint num, logic [30:0] per,
                                               logic [30:0] bus);
        logic [127:0] prod;
        logic [127:0] q;
        if (num <= 0)
            return '0;
        prod = 128'(num) * {97'b0, per};
        q = prod / ({97'b0, bus} << 29);
        return (q > {97'b0, TIME_MAX}) ? TIME_MAX : q[30:0];
    endfunction

    function automatic phase_times_t svm_predict(logic signed [31:0] al,
                                                 logic signed [31:0] be,
                                                 logic [30:0] bus, logic [30:0] per);
        longint a, b, b28, a28, sa, sb, x2, y2, z2, n1, n2;
        logic [30:0] t1, t2, sum, half, full, mid1, mid2;
        phase_times_t r;
        a = al;
        b = be;
        b28 = b * 268435456;
        a28 = a * 268435456;
        sa = a * longint'(SQRT3_Q28);
        sb = b * longint'(SQRT3_Q28);
        x2 = 2 * sb;
        y2 = sb + 3 * a28;
        z2 = sb - 3 * a28;
        r = '0;
        if (a == 0 && b == 0)
            r.sec = SECTOR_1;
        else if (b >= 0)
            r.sec = (b28 < sa) ? SECTOR_1 : (b28 > -sa) ? SECTOR_2 : SECTOR_3;
        else
            r.sec = (b28 > sa) ? SECTOR_4 : (b28 < -sa) ? SECTOR_5 : SECTOR_6;
        case (r.sec)
            SECTOR_1: begin n1 = -z2; n2 = x2;  end
            SECTOR_2: begin n1 = y2;  n2 = z2;  end
            SECTOR_3: begin n1 = x2;  n2 = -y2; end
            SECTOR_4: begin n1 = z2;  n2 = -x2; end
            SECTOR_5: begin n1 = -y2; n2 = -z2; end
            default:  begin n1 = -x2; n2 = y2;  end
        endcase
        if (bus == 0) begin
            r.bz = 1'b1;
            return r;
        end
        t1 = dwell_time(n1, per, bus);
        t2 = dwell_time(n2, per, bus);
        sum = sat_add(t1, t2);
        half = '0;
        if (sum > per)
            r.over = 1'b1;
        else
            half = (per - sum) >> 1;
        full = sat_add(sum, half);
        mid1 = sat_add(t1, half);
        mid2 = sat_add(t2, half);
        case (r.sec)
            SECTOR_1: begin r.tu = {1'b0, full}; r.tv = {1'b0, mid2}; r.tw = {1'b0, half}; end
            SECTOR_2: begin r.tv = {1'b0, full}; r.tu = {1'b0, mid1}; r.tw = {1'b0, half}; end
            SECTOR_3: begin r.tv = {1'b0, full}; r.tw = {1'b0, mid2}; r.tu = {1'b0, half}; end
            SECTOR_4: begin r.tw = {1'b0, full}; r.tv = {1'b0, mid1}; r.tu = {1'b0, half}; end
            SECTOR_5: begin r.tw = {1'b0, full}; r.tu = {1'b0, mid2}; r.tv = {1'b0, half}; end
            default:  begin r.tu = {1'b0, full}; r.tw = {1'b0, mid1}; r.tv = {1'b0, half}; end
        endcase
        return r;
    endfunction

    task automatic report(string field, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field,
                     exp_v, act_v);
            fail_count++;
        end
    endtask

    initial begin
        fail_count = 0;
        pending = 0;
        period = PERIOD_RESET;
    end

    always @(posedge clk or negedge rst_n) begin
        phase_times_t e;
        if (!rst_n) begin
            period = PERIOD_RESET;
        end else begin
            if (cfg_wr_en)
                period = cfg_wr_data;
            if (in_valid && !in_stall)
                expected_times.push_back(svm_predict(alpha_voltage, beta_voltage,
                                                     bus_voltage, period));
            if (out_valid && !out_stall) begin
                if (expected_times.size() == 0) begin
                    $display("%0t: unexpected result beat, sector %0d", $realtime, sector);
                    fail_count++;
                end else begin
                    e = expected_times.pop_front();
                    report("sector", {29'b0, e.sec}, {29'b0, sector});
                    report("time_u", e.tu, time_u);
                    report("time_v", e.tv, time_v);
                    report("time_w", e.tw, time_w);
                    report("overmodulated", {31'b0, e.over}, {31'b0, overmodulated});
                    report("bus_zero", {31'b0, e.bz}, {31'b0, bus_zero});
                end
            end
            pending = expected_times.size();
        end
    end
endmodule
`default_nettype wire

### tb/tb_space_vector_modulation_top.sv
`default_nettype none
module tb_space_vector_modulation_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [30:0]        cfg_wr_data;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] alpha_voltage;
    logic signed [31:0] beta_voltage;
    logic [30:0]        bus_voltage;
    logic               out_valid;
    logic               out_stall;
    logic [2:0]         sector;
    logic signed [31:0] time_u;
    logic signed [31:0] time_v;
    logic signed [31:0] time_w;
    logic               overmodulated;
    logic               bus_zero;
    int                 fail_count;
    int                 pending;
    logic               quiet;
    logic               hold_req;

    space_vector_modulation_top uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .alpha_voltage(alpha_voltage), .beta_voltage(beta_voltage),
        .bus_voltage(bus_voltage),
        .out_valid(out_valid), .out_stall(out_stall),
        .sector(sector), .time_u(time_u), .time_v(time_v), .time_w(time_w),
        .overmodulated(overmodulated), .bus_zero(bus_zero)
    );

    svm_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .alpha_voltage(alpha_voltage), .beta_voltage(beta_voltage),
        .bus_voltage(bus_voltage),
        .out_valid(out_valid), .out_stall(out_stall),
        .sector(sector), .time_u(time_u), .time_v(time_v), .time_w(time_w),
        .overmodulated(overmodulated), .bus_zero(bus_zero),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #2ms;
        $display("CHECKS FAILED");
        $finish;
    end

    // result side stalls
    initial begin
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                out_stall = 1'b1;
                repeat (200) @(negedge clk);
                hold_req = 1'b0;
                out_stall = 1'b0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 6)) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_vector(logic signed [31:0] al, logic signed [31:0] be,
                               logic [30:0] bus);
        logic taken;
        alpha_voltage = al;
        beta_voltage = be;
        bus_voltage = bus;
        in_valid = 1'b1;
        taken = 1'b0;
        while (!taken) begin
            @(posedge clk);
            taken = !in_stall;
            @(negedge clk);
        end
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    endtask

    task automatic send_random;
        int unsigned bus;
        case ($urandom_range(0, 9))
            0: send_vector($urandom, $urandom, 31'($urandom));
            1: send_vector($urandom, $urandom, '0);
            2: send_vector($urandom_range(0, 2000) - 1000, $urandom_range(0, 2000) - 1000,
                           31'($urandom_range(1, 3000)));
            default: begin
                bus = $urandom_range(1, 1 << 24);
                send_vector(int'($urandom_range(0, bus)) - int'(bus / 2),
                            int'($urandom_range(0, bus)) - int'(bus / 2), 31'(bus));
            end
        endcase
    endtask

    task automatic drain;
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_period(logic [30:0] value);
        cfg_wr_en = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    initial begin
        logic [30:0] periods[5];
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_valid = 1'b0;
        alpha_voltage = '0;
        beta_voltage = '0;
        bus_voltage = '0;
        quiet = 1'b0;
        hold_req = 1'b0;
        periods = '{31'd65536, 31'd0, 31'h7FFFFFFF, 31'd1000, 31'd1};
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: zero vector, axes, sector edges, extremes, zero bus, overmodulation
        send_vector(0, 0, 31'd65536);
        send_vector(1000, 0, 31'd65536);
        send_vector(-1000, 0, 31'd65536);
        send_vector(0, 1000, 31'd65536);
        send_vector(0, -1000, 31'd65536);
        send_vector(32'sd33554432, 32'sd58117981, 31'h7FFFFFFF);
        send_vector(-32'sd33554432, 32'sd58117981, 31'h7FFFFFFF);
        send_vector(32'sd33554432, -32'sd58117981, 31'h7FFFFFFF);
        send_vector(-32'sd33554432, -32'sd58117981, 31'h7FFFFFFF);
        send_vector(32'sh80000000, 32'sh80000000, 31'd1);
        send_vector(32'sh7FFFFFFF, 32'sh7FFFFFFF, 31'd1);
        send_vector(32'sh7FFFFFFF, 32'sh80000000, 31'h7FFFFFFF);
        send_vector(32'sh80000000, 32'sh7FFFFFFF, 31'd0);
        send_vector(500, 300, 31'd0);
        send_vector(60000, 20000, 31'd65536);
        send_vector(-40000, -50000, 31'd65536);
        send_vector(20000, -45000, 31'd65536);
        send_vector(-3, 1, 31'd10);

        foreach (periods[p]) begin
            drain();
            write_period(periods[p]);
            if (p == 2) begin
                hold_req = 1'b1;
                repeat (80) send_random();
                drain();
            end else begin
                repeat (60) send_random();
            end
        end
        drain();
        write_period(31'($urandom));
        repeat (100) send_random();
        quiet = 1'b1;
        repeat (80) send_random();
        drain();

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire

### sim.f
+incdir+rtl
rtl/svm_pkg.sv
rtl/svm_front.sv
rtl/svm_mul.sv
rtl/svm_div.sv
rtl/svm_map.sv
rtl/space_vector_modulation_top.sv
tb/svm_checker.sv
tb/tb_space_vector_modulation_top.sv
